// ===== src/pga_pkg.sv =====
// shared types and constants for the pairwise ground affinity block
`default_nettype none
package pga_pkg;

    localparam int CoordW = 24;
    localparam int DistW = 25;
    localparam int SimW = 17;
    localparam int RadW = 24;
    localparam int SqW = 50;
    localparam int RemW = 27;
    localparam int DivRemW = 25;

    localparam logic [DistW-1:0] DIST_MAX = 25'h1FFFFFF;
    localparam logic [SimW-1:0] SIM_ONE = 17'h10000;

    localparam logic CFG_SIM_RADIUS = 1'b0;
    localparam logic CFG_GATE_RADIUS = 1'b1;

    typedef struct packed {
        logic signed [CoordW-1:0] row_x;
        logic signed [CoordW-1:0] row_y;
        logic row_known;
        logic signed [CoordW-1:0] col_x;
        logic signed [CoordW-1:0] col_y;
        logic col_known;
        logic on_diagonal;
        logic last_pair;
    } pga_in_t;

    typedef struct packed {
        logic [DistW-1:0] distance;
        logic distance_known;
        logic [SimW-1:0] similarity;
        logic gate_allowed;
        logic last_out;
    } pga_out_t;

    // flags riding along the front and root stages
    typedef struct packed {
        logic known;
        logic diag;
        logic last;
    } pga_side_t;

    // everything settled before the divider
    typedef struct packed {
        logic known;
        logic diag;
        logic last;
        logic gate;
        logic sim_en;
        logic [DistW-1:0] dist_sat;
    } pga_res_t;

endpackage
`default_nettype wire

// ===== src/pga_sqrt_cell.sv =====
// one bit of the pipelined integer square root
`default_nettype none
module pga_sqrt_cell
    import pga_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic adv,
    input  wire logic valid_in,
    input  wire logic [SqW-1:0] rad_in,
    input  wire logic [RemW-1:0] rem_in,
    input  wire logic [DistW-1:0] root_in,
    input  wire pga_side_t side_in,
    output logic valid_reg,
    output logic [SqW-1:0] rad_reg,
    output logic [RemW-1:0] rem_reg,
    output logic [DistW-1:0] root_reg,
    output pga_side_t side_reg
);

    logic [RemW+1:0] rem4;
    logic [RemW+1:0] trial;
    logic ge;
    logic [RemW-1:0] rem_next;
    logic [DistW-1:0] root_next;

    always_comb
    begin
        rem4 = {rem_in, rad_in[SqW-1 -: 2]};
        trial = {2'b00, root_in, 2'b01};
        ge = (rem4 >= trial);
        rem_next = ge ? RemW'(rem4 - trial) : RemW'(rem4);
        root_next = {root_in[DistW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rad_reg <= {rad_in[SqW-3:0], 2'b00};
            rem_reg <= rem_next;
            root_reg <= root_next;
            side_reg <= side_in;
        end
    end

endmodule
`default_nettype wire

// ===== src/pga_div_cell.sv =====
// one quotient bit of the pipelined similarity divider
`default_nettype none
module pga_div_cell
    import pga_pkg::*;
#(
    parameter bit SHIFT = 1'b1
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic adv,
    input  wire logic [RadW-1:0] divisor,
    input  wire logic valid_in,
    input  wire logic [DivRemW-1:0] rem_in,
    input  wire logic [SimW-1:0] q_in,
    input  wire pga_res_t res_in,
    output logic valid_reg,
    output logic [DivRemW-1:0] rem_reg,
    output logic [SimW-1:0] q_reg,
    output pga_res_t res_reg
);

    logic [DivRemW-1:0] cand;
    logic ge;

    always_comb
    begin
        cand = SHIFT ? {rem_in[DivRemW-2:0], 1'b0} : rem_in;
        ge = (cand >= {1'b0, divisor});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg <= ge ? (cand - {1'b0, divisor}) : cand;
            q_reg <= {q_in[SimW-2:0], ge};
            res_reg <= res_in;
        end
    end

endmodule
`default_nettype wire

// ===== src/pairwise_ground_affinity_top.sv =====
// pairwise ground affinity: distance, similarity and gate for one point pair a cycle when not stalled
//
// Fully pipelined: one request is taken every cycle while not stalled. Each result
// passes three front stages for differences, squares and sum, 25 square-root cells,
// one compare stage and 17 divider cells. The whole pipe moves together and stalls
// only while the output register holds a result that is not taken. Radii must be
// written while the pipe is empty.
`default_nettype none
module pairwise_ground_affinity_top
    import pga_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_write,
    input  wire logic cfg_index,
    input  wire logic [RadW-1:0] cfg_data,
    input  wire logic in_valid,
    output logic in_stall,
    input  wire pga_in_t in_data,
    output logic out_valid,
    input  wire logic out_stall,
    output pga_out_t out_data
);

    localparam int SqrtN = DistW;
    localparam int DivN = SimW;

    logic [RadW-1:0] sim_radius_reg;
    logic [RadW-1:0] gate_radius_reg;
    logic adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sim_radius_reg <= '0;
            gate_radius_reg <= '0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_SIM_RADIUS)
                sim_radius_reg <= cfg_data;
            else
                gate_radius_reg <= cfg_data;
        end
    end

    assign adv = !(out_valid && out_stall);
    assign in_stall = !adv;

    // front stages
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    pga_side_t s1_side_reg, s2_side_reg, s3_side_reg;
    logic [DistW-1:0] ax_reg, ay_reg;
    logic [2*DistW-2:0] sqx_reg, sqy_reg;
    logic [SqW-1:0] sum_reg;
    logic signed [DistW-1:0] dx, dy;

    always_comb
    begin
        dx = DistW'(in_data.row_x) - DistW'(in_data.col_x);
        dy = DistW'(in_data.row_y) - DistW'(in_data.col_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax_reg <= dx[DistW-1] ? DistW'(-dx) : DistW'(dx);
            ay_reg <= dy[DistW-1] ? DistW'(-dy) : DistW'(dy);
            s1_side_reg <= '{known: in_data.row_known & in_data.col_known,
                             diag: in_data.on_diagonal, last: in_data.last_pair};
            sqx_reg <= (2*DistW-1)'(ax_reg * ax_reg);
            sqy_reg <= (2*DistW-1)'(ay_reg * ay_reg);
            s2_side_reg <= s1_side_reg;
            sum_reg <= SqW'(sqx_reg) + SqW'(sqy_reg);
            s3_side_reg <= s2_side_reg;
        end
    end

    // square root chain
    logic [SqrtN:0] sq_valid;
    logic [SqW-1:0] sq_rad [SqrtN+1];
    logic [RemW-1:0] sq_rem [SqrtN+1];
    logic [DistW-1:0] sq_root [SqrtN+1];
    pga_side_t sq_side [SqrtN+1];

    assign sq_valid[0] = s3_valid_reg;
    assign sq_rad[0] = sum_reg;
    assign sq_rem[0] = '0;
    assign sq_root[0] = '0;
    assign sq_side[0] = s3_side_reg;

    genvar gi;
    generate
        for (gi = 0; gi < SqrtN; gi++)
        begin : g_sqrt
            pga_sqrt_cell u_cell (
                .clk(clk), .rst_n(rst_n), .adv(adv),
                .valid_in(sq_valid[gi]), .rad_in(sq_rad[gi]), .rem_in(sq_rem[gi]),
                .root_in(sq_root[gi]), .side_in(sq_side[gi]),
                .valid_reg(sq_valid[gi+1]), .rad_reg(sq_rad[gi+1]),
                .rem_reg(sq_rem[gi+1]), .root_reg(sq_root[gi+1]),
                .side_reg(sq_side[gi+1])
            );
        end
    endgenerate

    // compare stage
    logic cmp_valid_reg;
    pga_res_t cmp_res_reg;
    logic [DivRemW-1:0] cmp_num_reg;
    logic [DistW-1:0] d;
    logic sim_en;

    always_comb
    begin
        d = sq_root[SqrtN];
        sim_en = sq_side[SqrtN].known && (d < {1'b0, sim_radius_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmp_valid_reg <= 1'b0;
        else if (adv)
            cmp_valid_reg <= sq_valid[SqrtN];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmp_res_reg.known <= sq_side[SqrtN].known;
            cmp_res_reg.diag <= sq_side[SqrtN].diag;
            cmp_res_reg.last <= sq_side[SqrtN].last;
            cmp_res_reg.gate <= !sq_side[SqrtN].known || (d < {1'b0, gate_radius_reg});
            cmp_res_reg.sim_en <= sim_en;
            cmp_res_reg.dist_sat <= sq_side[SqrtN].known ? d : DIST_MAX;
            cmp_num_reg <= {1'b0, sim_radius_reg} - d;
        end
    end

    // divider chain: (radius - distance) * 65536 / radius
    logic [DivN:0] dv_valid;
    logic [DivRemW-1:0] dv_rem [DivN+1];
    logic [SimW-1:0] dv_q [DivN+1];
    pga_res_t dv_res [DivN+1];

    assign dv_valid[0] = cmp_valid_reg;
    assign dv_rem[0] = cmp_num_reg;
    assign dv_q[0] = '0;
    assign dv_res[0] = cmp_res_reg;

    generate
        for (gi = 0; gi < DivN; gi++)
        begin : g_div
            pga_div_cell #(.SHIFT(gi != 0)) u_cell (
                .clk(clk), .rst_n(rst_n), .adv(adv), .divisor(sim_radius_reg),
                .valid_in(dv_valid[gi]), .rem_in(dv_rem[gi]), .q_in(dv_q[gi]),
                .res_in(dv_res[gi]),
                .valid_reg(dv_valid[gi+1]), .rem_reg(dv_rem[gi+1]),
                .q_reg(dv_q[gi+1]), .res_reg(dv_res[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        out_valid = dv_valid[DivN];
        out_data.distance = dv_res[DivN].dist_sat;
        out_data.distance_known = dv_res[DivN].known;
        out_data.similarity = dv_res[DivN].diag ? SIM_ONE
                            : (dv_res[DivN].sim_en ? dv_q[DivN] : '0);
        out_data.gate_allowed = dv_res[DivN].gate;
        out_data.last_out = dv_res[DivN].last;
    end

    a_unknown_gate: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.distance_known |-> out_data.gate_allowed)
        else $error("unknown distance must pass gate");

    a_unknown_dist: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.distance_known |-> out_data.distance == DIST_MAX)
        else $error("unknown distance must be saturated");

    a_sim_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.similarity <= SIM_ONE)
        else $error("similarity above one");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

endmodule
`default_nettype wire
